FILE: hw/rtl/stable_priority_queue_with_cancel_unit_defines.svh
// Assertion macros shared by the checker of the priority queue unit.
// Depends on nothing; included by the checker file only.
`ifndef STABLE_PRIORITY_QUEUE_WITH_CANCEL_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_WITH_CANCEL_UNIT_DEFINES_SVH

// Property checked at every rising clock edge, held off while reset is low.
`define SPQC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define SPQC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/spqc_pkg.sv
// Shared types and constants of the stable priority queue unit.
// No dependencies; used by the top level and the checker.
`default_nettype none

package spqc_pkg;

    localparam int ID_W       = 8;
    localparam int PRIO_W     = 3;
    localparam int OCC_W      = 4;
    localparam int DEPTH_DEF  = 8;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   req_id;
        logic [PRIO_W-1:0] req_priority;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              out_valid;
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

FILE: hw/rtl/spqc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module spqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stable_priority_queue_with_cancel_unit.sv
// Top level of the stable priority queue with cancel.
// Depends on spqc_pkg and spqc_ram.
//
// Usage: an item (push, pop or cancel) is taken at a clock edge where start
// is high and busy is low. Exactly one result per item is shown on o_result
// for one cycle, marked by o_done; the receiver cannot hold it off.
// Entries sit in one RAM with a registered read port, front at address 0.
// A sequencer walks the RAM entry by entry; each step is a read, then a
// compare, a write of the moved entry, or both.
// A full push, an empty pop and an unused kind finish without a RAM walk.
// busy is high from the cycle after accept up to the cycle before o_done, so
// a new item can be taken in the cycle that shows the previous result.
// Reset empties the queue at once; RAM contents are left as they are, and
// slots at or beyond the count are never read.
`default_nettype none

module stable_priority_queue_with_cancel_unit
    import spqc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_item   i_item,
    output logic         busy,
    output logic         o_done,
    output t_result      o_result
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PUSH_RD  = 8'b0000_0010,
        S_PUSH_CMP = 8'b0000_0100,
        S_POP_CAP  = 8'b0000_1000,
        S_GAP_RD   = 8'b0001_0000,
        S_GAP_WR   = 8'b0010_0000,
        S_CAN_RD   = 8'b0100_0000,
        S_CAN_CMP  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [1:0]        r_kind;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    t_entry            r_front, n_front;
    logic              r_done, n_done;
    t_result           r_res, n_res;

    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  pos_p1;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    t_entry            ram_rdata;
    logic              accept;

    assign accept = start && !busy;
    assign pos_m1 = r_pos - 1'b1;
    assign pos_p1 = r_pos + 1'b1;

    spqc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_front   = r_front;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.out_valid    = 1'b0;
                    n_res.out_id       = '0;
                    n_res.out_priority = '0;
                    n_res.status       = ST_DONE;
                    n_res.occupancy    = OCC_W'(r_count);
                    n_pos              = '0;
                    if (i_item.kind == KIND_PUSH) begin
                        if (r_count == FULL_CNT) begin
                            n_res.status = ST_FULL;
                            n_done       = 1'b1;
                        end else begin
                            n_pos   = r_count;
                            n_state = S_PUSH_RD;
                        end
                    end else if (i_item.kind == KIND_POP) begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_done       = 1'b1;
                        end else begin
                            ram_raddr = '0;
                            n_state   = S_POP_CAP;
                        end
                    end else if (i_item.kind == KIND_CANCEL) begin
                        n_state = S_CAN_RD;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_PUSH_RD: begin
                if (r_pos == '0) begin
                    ram_we          = 1'b1;
                    ram_waddr       = '0;
                    ram_wdata       = '{prio: r_prio, id: r_id};
                    n_count         = r_count + 1'b1;
                    n_res.occupancy = OCC_W'(n_count);
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    ram_raddr = pos_m1[IDX_W-1:0];
                    n_state   = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[IDX_W-1:0];
                if (ram_rdata.prio < r_prio) begin
                    // Lower-priority entry moves back one slot.
                    ram_wdata = ram_rdata;
                    n_pos     = pos_m1;
                    n_state   = S_PUSH_RD;
                end else begin
                    ram_wdata       = '{prio: r_prio, id: r_id};
                    n_count         = r_count + 1'b1;
                    n_res.occupancy = OCC_W'(n_count);
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_POP_CAP: begin
                n_front = ram_rdata;
                n_pos   = '0;
                n_state = S_GAP_RD;
            end
            S_GAP_RD: begin
                if (pos_p1 >= r_count) begin
                    n_count         = r_count - 1'b1;
                    n_res.occupancy = OCC_W'(n_count);
                    n_res.status    = ST_DONE;
                    if (r_kind == KIND_POP) begin
                        n_res.out_valid    = 1'b1;
                        n_res.out_id       = r_front.id;
                        n_res.out_priority = r_front.prio;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = pos_p1[IDX_W-1:0];
                    n_state   = S_GAP_WR;
                end
            end
            S_GAP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_pos     = pos_p1;
                n_state   = S_GAP_RD;
            end
            S_CAN_RD: begin
                if (r_pos >= r_count) begin
                    n_res.status = ST_NOT_FOUND;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    ram_raddr = r_pos[IDX_W-1:0];
                    n_state   = S_CAN_CMP;
                end
            end
            S_CAN_CMP: begin
                if (ram_rdata.id == r_id) begin
                    n_state = S_GAP_RD;
                end else begin
                    n_pos   = pos_p1;
                    n_state = S_CAN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_front <= n_front;
        r_res   <= n_res;
        if (accept) begin
            r_kind <= i_item.kind;
            r_id   <= i_item.req_id;
            r_prio <= i_item.req_priority;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: hw/rtl/spqc_checker.sv
// Port-level checker for the stable priority queue unit, with its bind.
// Depends on spqc_pkg and the assertion macro header.
`default_nettype none
`include "stable_priority_queue_with_cancel_unit_defines.svh"

module spqc_checker
    import spqc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_done,
    input wire t_result o_result
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    // An accepted item either finishes at once or keeps the unit busy.
    `SPQC_ASSERT(a_accept_progress, i_clk, i_rst_n, (start && !busy) |=> (busy || o_done), "accepted item neither started nor finished")

    // A result is only shown once the unit is free for the next item.
    `SPQC_ASSERT(a_done_not_busy, i_clk, i_rst_n, o_done |-> !busy, "result shown while still busy")

    // A returned entry always comes with a done status.
    `SPQC_ASSERT(a_pop_status, i_clk, i_rst_n, (o_done && o_result.out_valid) |-> (o_result.status == ST_DONE), "popped entry without done status")

    // A refused push reports a full queue.
    `SPQC_ASSERT(a_full_occ, i_clk, i_rst_n, (o_done && o_result.status == ST_FULL) |-> (o_result.occupancy == FULL_OCC), "full status with queue not full")

    // No result strobe once reset has been sampled low.
    `SPQC_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_done, "result strobe after reset")

endmodule

bind stable_priority_queue_with_cancel_unit spqc_checker #(
    .DEPTH (DEPTH)
) u_spqc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
